### sv/prm_pkg.sv
// Shared types and constants for the packet ring mailbox.
package prm_pkg;

	localparam int SEQ_W  = 32;
	localparam int KIND_W = 8;
	localparam int SUM_W  = 32;

	localparam logic [SUM_W-1:0] FNV_BASIS = 32'd2166136261;
	localparam logic [SUM_W-1:0] FNV_PRIME = 32'd16777619;

	localparam logic [2:0] STS_TAKEN     = 3'd0;
	localparam logic [2:0] STS_COMMIT    = 3'd1;
	localparam logic [2:0] STS_DROP_FULL = 3'd2;
	localparam logic [2:0] STS_DROP_LONG = 3'd3;
	localparam logic [2:0] STS_READ      = 3'd4;
	localparam logic [2:0] STS_EMPTY     = 3'd5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [1:0] DROP_NONE = 2'd0;
	localparam logic [1:0] DROP_FULL = 2'd1;
	localparam logic [1:0] DROP_LONG = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

### sv/prm_store.sv
// Payload and slot header memories, registered read.
module prm_store #(
	parameter int SLOTS       = 16,
	parameter int MAX_PAYLOAD = 256,
	localparam int OFF_W  = $clog2(MAX_PAYLOAD + 1),
	localparam int SLOT_W = $clog2(SLOTS),
	localparam int DEPTH  = SLOTS * MAX_PAYLOAD,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int HDR_W  = prm_pkg::SEQ_W + prm_pkg::KIND_W + OFF_W + prm_pkg::SUM_W
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] pay_rd_addr,
	input  logic [SLOT_W-1:0] hdr_rd_addr,
	input  logic              pay_we,
	input  logic [ADDR_W-1:0] pay_wr_addr,
	input  logic [7:0]        pay_wr_data,
	input  logic              hdr_we,
	input  logic [SLOT_W-1:0] hdr_wr_addr,
	input  logic [HDR_W-1:0]  hdr_wr_data,
	output logic [7:0]        pay_rd_data,
	output logic [HDR_W-1:0]  hdr_rd_data
);
	logic [7:0]       pay_mem [DEPTH];
	logic [HDR_W-1:0] hdr_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_wr_addr] <= pay_wr_data;
		end
		if (rd_en) begin
			pay_rd_data <= pay_mem[pay_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[hdr_wr_addr] <= hdr_wr_data;
		end
		if (rd_en) begin
			hdr_rd_data <= hdr_mem[hdr_rd_addr];
		end
	end

endmodule

### sv/packet_ring_mailbox_fnv.sv
// Packet ring mailbox top level: write/commit/read control with FNV-1a checksum.
//
//  channel  | handshake        | ports
//  ---------+------------------+------------------------------------------------
//  command  | start / busy     | command, data_byte, has_byte, last, packet_type
//  result   | done (strobe)    | status, read_byte, read_last, seq_id, type_out,
//           |                  | packet_length, checksum, unread_count,
//           |                  | total_sent, total_received
//
// For every word, the accept edge issues the memory reads, the next cycle
// reads, modifies and writes back the slot state, and done follows in the
// cycle after that while busy is already low again. The memory read is
// registered. Reset clears the counters and control state only; the memories
// are never cleared, so no pass follows reset. The receiver cannot stall.
module packet_ring_mailbox_fnv #(
	parameter int SLOTS       = 16,
	parameter int MAX_PAYLOAD = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic [7:0]  packet_type,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  read_byte,
	output logic        read_last,
	output logic [31:0] seq_id,
	output logic [7:0]  type_out,
	output logic [8:0]  packet_length,
	output logic [31:0] checksum,
	output logic [4:0]  unread_count,
	output logic [63:0] total_sent,
	output logic [63:0] total_received
);
	localparam int OFF_W  = $clog2(MAX_PAYLOAD + 1);
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int DEPTH  = SLOTS * MAX_PAYLOAD;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic [prm_pkg::SEQ_W-1:0]  seq;
		logic [prm_pkg::KIND_W-1:0] kind;
		logic [OFF_W-1:0]           len;
		logic [prm_pkg::SUM_W-1:0]  sum;
	} hdr_t;

	prm_pkg::state_t state_q;

	logic        cmd_q;
	logic [7:0]  data_q;
	logic        has_q;
	logic        last_q;
	logic [7:0]  ptype_q;

	logic [31:0]       head_q, tail_q;
	logic [SLOT_W-1:0] head_slot_q, tail_slot_q;
	logic [63:0]       sent_q, recv_q;
	logic [OFF_W-1:0]  woff_q, roff_q;
	logic [31:0]       hash_q;
	logic [1:0]        drop_q;

	logic             done_q;
	logic [2:0]       status_q;
	logic [7:0]       rbyte_q;
	logic             rlast_q;
	logic [31:0]      seq_q;
	logic [7:0]       kind_q;
	logic [OFF_W-1:0] len_q;
	logic [31:0]      sum_q;

	logic              accept;
	logic              exec;
	logic [ADDR_W-1:0] head_base, tail_base;
	logic [ADDR_W-1:0] pay_rd_addr, pay_wr_addr;
	logic [7:0]        pay_rd_data;
	hdr_t              hdr_rd, hdr_wr;
	logic              pay_we, hdr_we;
	logic [31:0]       unread;
	logic [SLOT_W-1:0] head_slot_inc, tail_slot_inc;

	// next-state values for one item
	logic [1:0]       drop_nx;
	logic [OFF_W-1:0] woff_nx, roff_nx, roff_inc, plen;
	logic [31:0]      hash_nx, hash_upd;
	logic             head_adv, tail_adv;
	logic [2:0]       sts_nx;
	logic [7:0]       rbyte_nx;
	logic             rlast_nx;
	logic [31:0]      seq_nx, sum_nx;
	logic [7:0]       kind_nx;
	logic [OFF_W-1:0] len_nx;

	assign accept = start && !busy;
	assign busy   = (state_q == prm_pkg::ST_EXEC);
	assign exec   = busy;
	assign unread = head_q - tail_q;

	assign head_base   = ADDR_W'(ADDR_W'(head_slot_q) * ADDR_W'(MAX_PAYLOAD));
	assign tail_base   = ADDR_W'(ADDR_W'(tail_slot_q) * ADDR_W'(MAX_PAYLOAD));
	assign pay_rd_addr = tail_base + ADDR_W'(roff_q);
	assign pay_wr_addr = head_base + ADDR_W'(woff_q);

	// slot index follows counter % SLOTS, including the jump at the 2^32 wrap
	assign head_slot_inc = (head_q == '1 || head_slot_q == SLOT_W'(SLOTS - 1)) ? '0
		: head_slot_q + 1'b1;
	assign tail_slot_inc = (tail_q == '1 || tail_slot_q == SLOT_W'(SLOTS - 1)) ? '0
		: tail_slot_q + 1'b1;

	prm_store #(
		.SLOTS       (SLOTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_store (
		.clk         (clk),
		.rd_en       (accept),
		.pay_rd_addr (pay_rd_addr),
		.hdr_rd_addr (tail_slot_q),
		.pay_we      (pay_we),
		.pay_wr_addr (pay_wr_addr),
		.pay_wr_data (data_q),
		.hdr_we      (hdr_we),
		.hdr_wr_addr (head_slot_q),
		.hdr_wr_data (hdr_wr),
		.pay_rd_data (pay_rd_data),
		.hdr_rd_data (hdr_rd)
	);

	assign hash_upd = 32'((hash_q ^ {24'd0, data_q}) * prm_pkg::FNV_PRIME);

	always_comb begin
		drop_nx  = drop_q;
		woff_nx  = woff_q;
		roff_nx  = roff_q;
		roff_inc = roff_q;
		plen     = '0;
		hash_nx  = hash_q;
		head_adv = 1'b0;
		tail_adv = 1'b0;
		pay_we   = 1'b0;
		hdr_we   = 1'b0;
		sts_nx   = prm_pkg::STS_TAKEN;
		rbyte_nx = '0;
		rlast_nx = 1'b0;
		seq_nx   = '0;
		kind_nx  = '0;
		len_nx   = '0;
		sum_nx   = '0;
		if (cmd_q == prm_pkg::CMD_WRITE) begin
			if (drop_q == prm_pkg::DROP_NONE) begin
				if (unread >= 32'(SLOTS)) begin
					drop_nx = prm_pkg::DROP_FULL;
				end else if (has_q && woff_q >= OFF_W'(MAX_PAYLOAD)) begin
					drop_nx = prm_pkg::DROP_LONG;
				end
			end
			if (drop_nx != prm_pkg::DROP_NONE) begin
				sts_nx = (drop_nx == prm_pkg::DROP_FULL) ? prm_pkg::STS_DROP_FULL
					: prm_pkg::STS_DROP_LONG;
				if (last_q) begin
					drop_nx = prm_pkg::DROP_NONE;
					woff_nx = '0;
					hash_nx = prm_pkg::FNV_BASIS;
				end
			end else begin
				if (has_q) begin
					pay_we  = exec;
					hash_nx = hash_upd;
					woff_nx = woff_q + 1'b1;
				end
				if (last_q) begin
					hdr_we   = exec;
					sts_nx   = prm_pkg::STS_COMMIT;
					seq_nx   = head_q + 32'd1;
					kind_nx  = ptype_q;
					len_nx   = woff_nx;
					sum_nx   = hash_nx;
					head_adv = 1'b1;
					woff_nx  = '0;
					hash_nx  = prm_pkg::FNV_BASIS;
				end
			end
		end else begin
			if (head_q == tail_q) begin
				sts_nx = prm_pkg::STS_EMPTY;
			end else begin
				plen    = (hdr_rd.len > OFF_W'(MAX_PAYLOAD)) ? OFF_W'(MAX_PAYLOAD) : hdr_rd.len;
				sts_nx  = prm_pkg::STS_READ;
				seq_nx  = hdr_rd.seq;
				kind_nx = hdr_rd.kind;
				len_nx  = plen;
				sum_nx  = hdr_rd.sum;
				if (roff_q < plen) begin
					rbyte_nx = pay_rd_data;
					roff_inc = roff_q + 1'b1;
				end
				roff_nx = roff_inc;
				if (roff_inc >= plen) begin
					rlast_nx = 1'b1;
					roff_nx  = '0;
					tail_adv = 1'b1;
				end
			end
		end
	end

	assign hdr_wr = '{seq: seq_nx, kind: kind_nx, len: len_nx, sum: sum_nx};

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			data_q  <= data_byte;
			has_q   <= has_byte;
			last_q  <= last;
			ptype_q <= packet_type;
		end
		if (exec) begin
			status_q <= sts_nx;
			rbyte_q  <= rbyte_nx;
			rlast_q  <= rlast_nx;
			seq_q    <= seq_nx;
			kind_q   <= kind_nx;
			len_q    <= len_nx;
			sum_q    <= sum_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prm_pkg::ST_IDLE;
			done_q      <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			head_slot_q <= '0;
			tail_slot_q <= '0;
			sent_q      <= '0;
			recv_q      <= '0;
			woff_q      <= '0;
			roff_q      <= '0;
			hash_q      <= prm_pkg::FNV_BASIS;
			drop_q      <= prm_pkg::DROP_NONE;
		end else begin
			done_q <= exec;
			unique case (state_q)
				prm_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= prm_pkg::ST_EXEC;
					end
				end
				prm_pkg::ST_EXEC: begin
					state_q <= prm_pkg::ST_IDLE;
					drop_q  <= drop_nx;
					woff_q  <= woff_nx;
					roff_q  <= roff_nx;
					hash_q  <= hash_nx;
					if (head_adv) begin
						head_q      <= head_q + 32'd1;
						head_slot_q <= head_slot_inc;
						sent_q      <= sent_q + 64'd1;
					end
					if (tail_adv) begin
						tail_q      <= tail_q + 32'd1;
						tail_slot_q <= tail_slot_inc;
						recv_q      <= recv_q + 64'd1;
					end
				end
				default: begin
					state_q <= prm_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign read_byte      = rbyte_q;
	assign read_last      = rlast_q;
	assign seq_id         = seq_q;
	assign type_out       = kind_q;
	assign packet_length  = 9'(len_q);
	assign checksum       = sum_q;
	assign unread_count   = 5'(unread);
	assign total_sent     = sent_q;
	assign total_received = recv_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done_q)
		else $error("accepted word produced no result");

	a_unread_bound: assert property (@(posedge clk) disable iff (!arst_n)
		unread <= 32'(SLOTS))
		else $error("ring holds more packets than slots");

	a_roff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		roff_q < OFF_W'(MAX_PAYLOAD))
		else $error("read offset past payload limit");

	a_commit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == prm_pkg::STS_COMMIT)
			|-> (drop_q == prm_pkg::DROP_NONE && woff_q == '0
				&& hash_q == prm_pkg::FNV_BASIS))
		else $error("write state not cleared after commit");

endmodule
